// ===== design/pppf_pkg.sv =====
// shared constants, types and functions for the ppp async transmit framer
package pppf_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [7:0]  CTRL_LIM  = 8'h20;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  // up to eight line bytes come out of one request
  localparam int unsigned SEQ_DEPTH = 8;
  localparam int unsigned SEQ_IDX_W = 3;

  typedef struct packed {
    logic [SEQ_DEPTH-1:0][7:0] bytes;
    logic [SEQ_IDX_W-1:0]      cnt_m1;
  } seq_t;

  // one byte of the reflected crc-16 update, bit at a time
  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ FCS_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  // control characters, escape and flag go out as an escape pair
  function automatic logic needs_escape(input logic [7:0] b);
    return (b < CTRL_LIM) || (b == ESC_BYTE) || (b == FLAG_BYTE);
  endfunction

endpackage

// ===== design/pppf_if.sv =====
// valid/ready channel interfaces for the framer input and output
interface pppf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface pppf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, output line_byte, output run_last, output frame_done,
                  input ready);
  modport sink   (input valid, input line_byte, input run_last, input frame_done,
                  output ready);
endinterface

// ===== design/pppf_expand.sv =====
// fcs update and expansion of one request into its line byte sequence
module pppf_expand (
  input  logic [7:0]     data_byte_i,
  input  logic           first_byte_i,
  input  logic           last_byte_i,
  input  logic [15:0]    fcs_i,
  output logic [15:0]    fcs_o,
  output pppf_pkg::seq_t seq_o
);

  logic [15:0] fcs_base;
  logic [15:0] fcs_new;
  logic [15:0] fcs_sent;
  logic [3:0]  n;
  logic [3:0]  n_m1;

  // restart the check sequence on an opening byte
  assign fcs_base = first_byte_i ? pppf_pkg::FCS_INIT : fcs_i;
  assign fcs_new  = pppf_pkg::fcs_update(fcs_base, data_byte_i);
  assign fcs_sent = ~fcs_new;
  assign fcs_o    = fcs_new;

  // flag if first, escaped data, and if last escaped fcs and flag
  always_comb begin
    seq_o.bytes = '0;
    n = 4'd0;
    if (first_byte_i) begin
      seq_o.bytes[n[2:0]] = pppf_pkg::FLAG_BYTE;
      n = n + 4'd1;
    end
    if (pppf_pkg::needs_escape(data_byte_i)) begin
      seq_o.bytes[n[2:0]] = pppf_pkg::ESC_BYTE;
      n = n + 4'd1;
      seq_o.bytes[n[2:0]] = data_byte_i ^ pppf_pkg::ESC_XOR;
    end else begin
      seq_o.bytes[n[2:0]] = data_byte_i;
    end
    n = n + 4'd1;
    if (last_byte_i) begin
      if (pppf_pkg::needs_escape(fcs_sent[7:0])) begin
        seq_o.bytes[n[2:0]] = pppf_pkg::ESC_BYTE;
        n = n + 4'd1;
        seq_o.bytes[n[2:0]] = fcs_sent[7:0] ^ pppf_pkg::ESC_XOR;
      end else begin
        seq_o.bytes[n[2:0]] = fcs_sent[7:0];
      end
      n = n + 4'd1;
      if (pppf_pkg::needs_escape(fcs_sent[15:8])) begin
        seq_o.bytes[n[2:0]] = pppf_pkg::ESC_BYTE;
        n = n + 4'd1;
        seq_o.bytes[n[2:0]] = fcs_sent[15:8] ^ pppf_pkg::ESC_XOR;
      end else begin
        seq_o.bytes[n[2:0]] = fcs_sent[15:8];
      end
      n = n + 4'd1;
      seq_o.bytes[n[2:0]] = pppf_pkg::FLAG_BYTE;
      n = n + 4'd1;
    end
    n_m1 = n - 4'd1;
    seq_o.cnt_m1 = n_m1[2:0];
  end

endmodule

// ===== design/ppp_async_tx_framer_fcs16_top.sv =====
// top level of the ppp asynchronous transmit framer with fcs-16
// Each request carries one unframed frame byte and produces one to eight line bytes,
// delivered one per cycle, while output ready is high, from a result register: an
// opening flag on the first byte, the byte itself or an escape pair, and after the
// last byte the complemented fcs (low byte first, escaped) and a closing flag. An
// input register in front of the output sequence register takes the next request
// while the current sequence drains, and that request moves across in the cycle the
// last line byte goes out. Input ready is low only while both registers are full, so
// input ready never waits on output ready in the same cycle. The fcs restarts only
// on a first byte; a byte outside an open frame is folded in and sent without flags.
// No reset sweep.
module ppp_async_tx_framer_fcs16_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pppf_in_if.sink     in_i,
  pppf_out_if.source  out_o
);

  logic                 a_valid_q;
  logic [7:0]           a_data_q;
  logic                 a_first_q;
  logic                 a_last_q;
  logic                 b_valid_q;
  logic                 b_last_q;
  logic [2:0]           ptr_q;
  pppf_pkg::seq_t       seq_q;
  pppf_pkg::seq_t       seq_d;
  logic [15:0]          fcs_q;
  logic [15:0]          fcs_d;
  logic                 in_fire;
  logic                 out_fire;
  logic                 b_finish;
  logic                 b_load;

  // handshake and stage movement
  assign in_i.ready = !a_valid_q || !b_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = b_valid_q && out_o.ready;
  assign b_finish   = out_fire && (ptr_q == seq_q.cnt_m1);
  assign b_load     = a_valid_q && (!b_valid_q || b_finish);

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (b_load) begin
      a_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_data_q  <= in_i.data_byte;
      a_first_q <= in_i.first_byte;
      a_last_q  <= in_i.last_byte;
    end
  end

  pppf_expand u_expand (
    .data_byte_i  (a_data_q),
    .first_byte_i (a_first_q),
    .last_byte_i  (a_last_q),
    .fcs_i        (fcs_q),
    .fcs_o        (fcs_d),
    .seq_o        (seq_d)
  );

  // running fcs and sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_q     <= pppf_pkg::FCS_INIT;
      b_valid_q <= 1'b0;
      ptr_q     <= '0;
    end else if (b_load) begin
      fcs_q     <= fcs_d;
      b_valid_q <= 1'b1;
      ptr_q     <= '0;
    end else if (b_finish) begin
      b_valid_q <= 1'b0;
    end else if (out_fire) begin
      ptr_q     <= ptr_q + 3'd1;
    end
  end

  // sequence payload
  always_ff @(posedge clk_i) begin
    if (b_load) begin
      seq_q    <= seq_d;
      b_last_q <= a_last_q;
    end
  end

  // result port
  assign out_o.valid      = b_valid_q;
  assign out_o.line_byte  = seq_q.bytes[ptr_q];
  assign out_o.run_last   = (ptr_q == seq_q.cnt_m1);
  assign out_o.frame_done = b_last_q && (ptr_q == seq_q.cnt_m1);

endmodule

// ===== design/pppf_checker.sv =====
// port level checks for the framer, bound to the top level
module pppf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] line_byte_i,
  input logic       run_last_i,
  input logic       frame_done_i
);

  // closing flag ends the request's output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> run_last_i && (line_byte_i == pppf_pkg::FLAG_BYTE))
    else $error("frame_done without closing flag at end of request");

  // an escape byte never ends a request, so its partner follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (line_byte_i == pppf_pkg::ESC_BYTE) |-> !run_last_i)
    else $error("escape byte ended a request");

  // with nothing pending on the output the input is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output idle");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_byte_i)
      && $stable(run_last_i) && $stable(frame_done_i))
    else $error("output changed while stalled");

endmodule

bind ppp_async_tx_framer_fcs16_top pppf_checker u_pppf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .line_byte_i  (out_o.line_byte),
  .run_last_i   (out_o.run_last),
  .frame_done_i (out_o.frame_done)
);
